### design/dnsm_pkg.sv
// Shared types, constants and elaboration-time functions of the drive noise synthesizer.
`default_nettype none

package dnsm_pkg;

  // Noise generator
  localparam logic [31:0] SEED_RESET = 32'h1234_5678;
  localparam logic [31:0] LCG_ADD    = 32'd1013904223;
  localparam logic signed [25:0] LCG_MUL = 26'sd1664525;

  // Filter coefficients, Q1.15
  localparam logic signed [25:0] WHIR_LP  = 26'sd6226;
  localparam logic signed [25:0] WHIR_HP  = 26'sd31359;
  localparam logic signed [25:0] CRACK_LP = 26'sd13107;
  localparam logic signed [25:0] CRACK_HP = 26'sd30147;

  // Envelope, Q1.24
  localparam logic [24:0] ENV_ONE       = 25'd16777216;
  localparam logic [24:0] ENV_TICK_GATE = 25'd167772;
  localparam logic [24:0] ENV_WHIR_GATE = 25'd16777;

  // Decay curve rates and default lengths
  localparam int unsigned CRACK_K      = 70;
  localparam int unsigned TICK_K       = 35;
  localparam int unsigned CRACK_LENGTH = 353;
  localparam int unsigned TICK_LENGTH  = 265;
  localparam logic [63:0] LOG2E_Q16    = 64'd94548;

  // Register reset values
  localparam logic [14:0] MOTOR_AMP_RESET  = 15'd1800;
  localparam logic [14:0] STEP_AMP_RESET   = 15'd14000;
  localparam logic [14:0] SECTOR_AMP_RESET = 15'd4000;
  localparam logic [15:0] INDEX_PER_RESET  = 16'd551;
  localparam logic [24:0] ATTACK_RESET     = 25'd951;
  localparam logic [24:0] DECAY_RESET      = 25'd476;

  // Register indexes
  localparam logic [2:0] REG_MOTOR_AMP  = 3'd0;
  localparam logic [2:0] REG_STEP_AMP   = 3'd1;
  localparam logic [2:0] REG_SECTOR_AMP = 3'd2;
  localparam logic [2:0] REG_INDEX_PER  = 3'd3;
  localparam logic [2:0] REG_ATTACK     = 3'd4;
  localparam logic [2:0] REG_DECAY      = 3'd5;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_MOTOR = 2'd1,
    OP_STEP  = 2'd2
  } op_e;

  typedef enum logic [4:0] {
    CMD_NOP,
    CMD_LOAD,
    CMD_MOTOR,
    CMD_STEP,
    CMD_GATE,
    CMD_NOISE_MUL,
    CMD_NOISE_WB,
    CMD_WLP1_MUL,
    CMD_WLP1_WB,
    CMD_WLP2_MUL,
    CMD_WLP2_WB,
    CMD_WHP_MUL,
    CMD_WHP_WB,
    CMD_WAMP_MUL,
    CMD_WENV_MUL,
    CMD_WACC,
    CMD_CLP_MUL,
    CMD_CLP_WB,
    CMD_CHP_MUL,
    CMD_CHP_WB,
    CMD_CAMP_MUL,
    CMD_CDEC_MUL,
    CMD_CACC,
    CMD_TAMP_MUL,
    CMD_TDEC_MUL,
    CMD_TACC,
    CMD_OUT
  } cmd_e;

  typedef struct packed {
    logic whir_act;
    logic crack_act;
    logic tick_act;
    logic out_free;
  } dp_status_t;

  function automatic logic signed [19:0] sat20(input logic signed [25:0] v);
    if (v > 26'sd524287) return 20'sd524287;
    if (v < -26'sd524288) return -20'sd524288;
    return 20'(v);
  endfunction

  // Restoring division, elaboration only
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], num[i]};
      if (r >= den) begin
        r = r - den;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
    logic [63:0] x;
    logic [63:0] res;
    logic [63:0] b;
    x   = x_in;
    res = '0;
    b   = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (b > x) b = b >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (b != 0) begin
        if (x >= res + b) begin
          x   = x - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
    end
    return res;
  endfunction

  // round(32768 * exp(-k * pos / len)) as 2^(-z) in fixed point
  function automatic logic [15:0] decay_val(input logic [63:0] k, input logic [63:0] pos,
                                            input logic [63:0] len);
    logic [63:0] y;
    logic [63:0] z;
    logic [63:0] n;
    logic [15:0] f;
    logic [63:0] v;
    logic [63:0] root;
    logic [63:0] s;
    y    = udiv64((k * pos) << 16, len);
    z    = (y * LOG2E_Q16) >> 16;
    n    = z >> 16;
    f    = z[15:0];
    v    = 64'd1 << 30;
    root = 64'd1 << 29;
    for (int i = 1; i <= 16; i++) begin
      if (i > 1) root = isqrt64(root << 30);
      if (f[16-i]) v = (v * root) >> 30;
    end
    if (n >= 64'd40) return 16'd0;
    s = 64'd15 + n;
    return 16'((v + (64'd1 << (s - 64'd1))) >> s);
  endfunction

endpackage

`default_nettype wire

### design/dnsm_ctrl.sv
// Sequencer of the drive noise synthesizer: walks one tick item through the shared multiplier.
`default_nettype none

module dnsm_ctrl (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  input  wire  [1:0]            op_i,
  input  dnsm_pkg::dp_status_t  status_i,
  output logic                  in_ready_o,
  output dnsm_pkg::cmd_e        cmd_o
);
  import dnsm_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_GATE, S_CHK,
    S_W_NMUL, S_W_NWB, S_W_LP1M, S_W_LP1W, S_W_LP2M, S_W_LP2W,
    S_W_HPM, S_W_HPW, S_W_AMPM, S_W_ENVM, S_W_ACC,
    S_C_NMUL, S_C_NWB, S_C_LPM, S_C_LPW, S_C_HPM, S_C_HPW,
    S_C_AMPM, S_C_DECM, S_C_ACC,
    S_T_NMUL, S_T_NWB, S_T_AMPM, S_T_DECM, S_T_ACC,
    S_OUT
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = CMD_NOP;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          unique case (op_e'(op_i))
            OP_TICK: begin
              cmd_o   = CMD_LOAD;
              state_d = S_GATE;
            end
            OP_MOTOR: cmd_o = CMD_MOTOR;
            OP_STEP:  cmd_o = CMD_STEP;
            default:  cmd_o = CMD_NOP;
          endcase
        end
      end
      S_GATE: begin
        cmd_o   = CMD_GATE;
        state_d = S_CHK;
      end
      S_CHK: begin
        if (status_i.whir_act)       state_d = S_W_NMUL;
        else if (status_i.crack_act) state_d = S_C_NMUL;
        else if (status_i.tick_act)  state_d = S_T_NMUL;
        else                         state_d = S_OUT;
      end
      S_W_NMUL: begin cmd_o = CMD_NOISE_MUL; state_d = S_W_NWB;  end
      S_W_NWB:  begin cmd_o = CMD_NOISE_WB;  state_d = S_W_LP1M; end
      S_W_LP1M: begin cmd_o = CMD_WLP1_MUL;  state_d = S_W_LP1W; end
      S_W_LP1W: begin cmd_o = CMD_WLP1_WB;   state_d = S_W_LP2M; end
      S_W_LP2M: begin cmd_o = CMD_WLP2_MUL;  state_d = S_W_LP2W; end
      S_W_LP2W: begin cmd_o = CMD_WLP2_WB;   state_d = S_W_HPM;  end
      S_W_HPM:  begin cmd_o = CMD_WHP_MUL;   state_d = S_W_HPW;  end
      S_W_HPW:  begin cmd_o = CMD_WHP_WB;    state_d = S_W_AMPM; end
      S_W_AMPM: begin cmd_o = CMD_WAMP_MUL;  state_d = S_W_ENVM; end
      S_W_ENVM: begin cmd_o = CMD_WENV_MUL;  state_d = S_W_ACC;  end
      S_W_ACC: begin
        cmd_o = CMD_WACC;
        if (status_i.crack_act)     state_d = S_C_NMUL;
        else if (status_i.tick_act) state_d = S_T_NMUL;
        else                        state_d = S_OUT;
      end
      S_C_NMUL: begin cmd_o = CMD_NOISE_MUL; state_d = S_C_NWB;  end
      S_C_NWB:  begin cmd_o = CMD_NOISE_WB;  state_d = S_C_LPM;  end
      S_C_LPM:  begin cmd_o = CMD_CLP_MUL;   state_d = S_C_LPW;  end
      S_C_LPW:  begin cmd_o = CMD_CLP_WB;    state_d = S_C_HPM;  end
      S_C_HPM:  begin cmd_o = CMD_CHP_MUL;   state_d = S_C_HPW;  end
      S_C_HPW:  begin cmd_o = CMD_CHP_WB;    state_d = S_C_AMPM; end
      S_C_AMPM: begin cmd_o = CMD_CAMP_MUL;  state_d = S_C_DECM; end
      S_C_DECM: begin cmd_o = CMD_CDEC_MUL;  state_d = S_C_ACC;  end
      S_C_ACC: begin
        cmd_o   = CMD_CACC;
        state_d = status_i.tick_act ? S_T_NMUL : S_OUT;
      end
      S_T_NMUL: begin cmd_o = CMD_NOISE_MUL; state_d = S_T_NWB;  end
      S_T_NWB:  begin cmd_o = CMD_NOISE_WB;  state_d = S_T_AMPM; end
      S_T_AMPM: begin cmd_o = CMD_TAMP_MUL;  state_d = S_T_DECM; end
      S_T_DECM: begin cmd_o = CMD_TDEC_MUL;  state_d = S_T_ACC;  end
      S_T_ACC:  begin cmd_o = CMD_TACC;      state_d = S_OUT;    end
      S_OUT: begin
        if (status_i.out_free) begin
          cmd_o   = CMD_OUT;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

### design/dnsm_datapath.sv
// Datapath of the drive noise synthesizer: state, config registers, shared multiplier, mixer.
`default_nettype none

module dnsm_datapath #(
  parameter int unsigned CrackLength = dnsm_pkg::CRACK_LENGTH,
  parameter int unsigned TickLength  = dnsm_pkg::TICK_LENGTH
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  dnsm_pkg::cmd_e        cmd_i,
  input  wire                   motor_on_i,
  input  wire  signed [15:0]    buzzer_sample_i,
  input  wire                   cfg_valid_i,
  input  wire  [2:0]            cfg_index_i,
  input  wire  [24:0]           cfg_data_i,
  input  wire                   out_ready_i,
  output logic                  out_valid_o,
  output logic signed [15:0]    mixed_sample_o,
  output dnsm_pkg::dp_status_t  status_o
);
  import dnsm_pkg::*;

  localparam int unsigned CrAw = $clog2(CrackLength);
  localparam int unsigned TkAw = $clog2(TickLength);
  localparam int unsigned CrDepth = 2 ** CrAw;
  localparam int unsigned TkDepth = 2 ** TkAw;

  typedef logic [15:0] crack_rom_t [CrDepth];
  typedef logic [15:0] tick_rom_t [TkDepth];

  function automatic crack_rom_t build_crack();
    crack_rom_t r;
    for (int i = 0; i < CrDepth; i++) begin
      r[i] = decay_val(64'(CRACK_K), 64'(i), 64'(CrackLength));
    end
    return r;
  endfunction

  function automatic tick_rom_t build_tick();
    tick_rom_t r;
    for (int i = 0; i < TkDepth; i++) begin
      r[i] = decay_val(64'(TICK_K), 64'(i), 64'(TickLength));
    end
    return r;
  endfunction

  localparam crack_rom_t CrackRom = build_crack();
  localparam tick_rom_t  TickRom  = build_tick();

  // Config registers
  logic [14:0] motor_amp_q, step_amp_q, sector_amp_q;
  logic [15:0] index_per_q;
  logic [24:0] attack_q, decay_q;

  // Synth state
  logic [31:0]        seed_q;
  logic               target_q;
  logic [24:0]        env_q;
  logic signed [19:0] wlp1_q, wlp2_q, whp_q, wprior_q;
  logic [8:0]         crack_rem_q, crack_pos_q;
  logic signed [19:0] clp_q, chp_q, cprior_q;
  logic [8:0]         tick_rem_q, tick_pos_q;
  logic [15:0]        index_cnt_q;

  // Working registers
  logic signed [61:0] p_q;
  logic signed [15:0] noise_q;
  logic signed [15:0] buz_q;
  logic signed [36:0] acc_q;
  logic [15:0]        crack_d_q, tick_d_q;
  logic               out_valid_q;
  logic signed [15:0] mixed_q;

  logic signed [35:0] mul_a;
  logic signed [25:0] mul_b;
  logic signed [61:0] rnd15, rnd24;
  logic signed [25:0] f_r;

  // Gate step
  logic [16:0] per, cnt_inc, cnt_next;
  logic        idx_wrap;
  logic [25:0] env_sum;
  logic [24:0] env_next;
  logic [31:0] seed_next;

  // Final mix
  logic [36:0]        acc_mag;
  logic [21:0]        acc_q15;
  logic signed [22:0] mix_v;
  logic signed [23:0] res_v;
  logic signed [15:0] res_sat;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i)
      CMD_NOISE_MUL: begin mul_a = 36'({4'b0, seed_q}); mul_b = LCG_MUL; end
      CMD_WLP1_MUL: begin
        mul_a = 36'(21'(noise_q) - 21'(wlp1_q)); mul_b = WHIR_LP;
      end
      CMD_WLP2_MUL: begin
        mul_a = 36'(21'(wlp1_q) - 21'(wlp2_q)); mul_b = WHIR_LP;
      end
      CMD_WHP_MUL: begin
        mul_a = 36'(22'(whp_q) + 22'(wlp2_q) - 22'(wprior_q)); mul_b = WHIR_HP;
      end
      CMD_WAMP_MUL: begin mul_a = 36'(whp_q); mul_b = $signed({11'b0, motor_amp_q}); end
      CMD_WENV_MUL: begin mul_a = 36'(p_q); mul_b = $signed({1'b0, env_q}); end
      CMD_CLP_MUL: begin
        mul_a = 36'(21'(noise_q) - 21'(clp_q)); mul_b = CRACK_LP;
      end
      CMD_CHP_MUL: begin
        mul_a = 36'(22'(chp_q) + 22'(clp_q) - 22'(cprior_q)); mul_b = CRACK_HP;
      end
      CMD_CAMP_MUL: begin mul_a = 36'(chp_q); mul_b = $signed({11'b0, step_amp_q}); end
      CMD_CDEC_MUL: begin mul_a = 36'(p_q); mul_b = $signed({10'b0, crack_d_q}); end
      CMD_TAMP_MUL: begin mul_a = 36'(noise_q); mul_b = $signed({11'b0, sector_amp_q}); end
      CMD_TDEC_MUL: begin mul_a = 36'(p_q); mul_b = $signed({10'b0, tick_d_q}); end
      default: ;
    endcase
  end

  assign rnd15 = (p_q + 62'sd16384) >>> 15;
  assign rnd24 = (p_q + 62'sd8388608) >>> 24;
  assign f_r   = $signed(rnd15[25:0]);
  assign seed_next = p_q[31:0] + LCG_ADD;

  always_comb begin
    per      = (index_per_q == '0) ? 17'd1 : {1'b0, index_per_q};
    cnt_inc  = {1'b0, index_cnt_q} + 17'd1;
    idx_wrap = (cnt_inc >= per);
    cnt_next = idx_wrap ? (cnt_inc - per) : cnt_inc;
    env_sum  = {1'b0, env_q} + {1'b0, attack_q};
    if (target_q) begin
      env_next = (env_sum > {1'b0, ENV_ONE}) ? ENV_ONE : env_sum[24:0];
    end else begin
      env_next = (decay_q >= env_q) ? '0 : (env_q - decay_q);
    end
  end

  always_comb begin
    acc_mag = acc_q[36] ? 37'(-acc_q) : 37'(acc_q);
    acc_q15 = acc_mag[36:15];
    mix_v   = acc_q[36] ? -$signed({1'b0, acc_q15}) : $signed({1'b0, acc_q15});
    res_v   = 24'(buz_q) + 24'(mix_v);
    if (res_v > 24'sd32767)       res_sat = 16'sd32767;
    else if (res_v < -24'sd32768) res_sat = -16'sd32768;
    else                          res_sat = 16'(res_v);
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    p_q       <= 62'(mul_a) * 62'(mul_b);
    crack_d_q <= CrackRom[crack_pos_q[CrAw-1:0]];
    tick_d_q  <= TickRom[tick_pos_q[TkAw-1:0]];
    if (cmd_i == CMD_LOAD) buz_q <= buzzer_sample_i;
    if (cmd_i == CMD_NOISE_WB) noise_q <= $signed(seed_next[31:16]);
    if (cmd_i == CMD_OUT) mixed_q <= res_sat;
    case (cmd_i)
      CMD_LOAD: acc_q <= '0;
      CMD_WACC: acc_q <= acc_q + 37'(rnd24);
      CMD_CACC, CMD_TACC: acc_q <= acc_q + 37'(rnd15);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      motor_amp_q  <= MOTOR_AMP_RESET;
      step_amp_q   <= STEP_AMP_RESET;
      sector_amp_q <= SECTOR_AMP_RESET;
      index_per_q  <= INDEX_PER_RESET;
      attack_q     <= ATTACK_RESET;
      decay_q      <= DECAY_RESET;
      seed_q       <= SEED_RESET;
      target_q     <= 1'b0;
      env_q        <= '0;
      wlp1_q       <= '0;
      wlp2_q       <= '0;
      whp_q        <= '0;
      wprior_q     <= '0;
      crack_rem_q  <= '0;
      crack_pos_q  <= '0;
      clp_q        <= '0;
      chp_q        <= '0;
      cprior_q     <= '0;
      tick_rem_q   <= '0;
      tick_pos_q   <= '0;
      index_cnt_q  <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          REG_MOTOR_AMP:  motor_amp_q  <= cfg_data_i[14:0];
          REG_STEP_AMP:   step_amp_q   <= cfg_data_i[14:0];
          REG_SECTOR_AMP: sector_amp_q <= cfg_data_i[14:0];
          REG_INDEX_PER:  index_per_q  <= cfg_data_i[15:0];
          REG_ATTACK:     attack_q     <= cfg_data_i;
          REG_DECAY:      decay_q      <= cfg_data_i;
          default: ;
        endcase
      end

      if (cmd_i == CMD_OUT)  out_valid_q <= 1'b1;
      else if (out_ready_i)  out_valid_q <= 1'b0;

      case (cmd_i)
        CMD_MOTOR: target_q <= motor_on_i;
        CMD_STEP: begin
          clp_q       <= '0;
          chp_q       <= '0;
          cprior_q    <= '0;
          crack_rem_q <= 9'(CrackLength);
          crack_pos_q <= '0;
        end
        CMD_GATE: begin
          if (env_q > ENV_TICK_GATE) begin
            index_cnt_q <= cnt_next[15:0];
            if (idx_wrap) begin
              tick_rem_q <= 9'(TickLength);
              tick_pos_q <= '0;
            end
          end
          env_q <= env_next;
        end
        CMD_NOISE_WB: seed_q <= seed_next;
        CMD_WLP1_WB:  wlp1_q <= sat20(26'(wlp1_q) + f_r);
        CMD_WLP2_WB:  wlp2_q <= sat20(26'(wlp2_q) + f_r);
        CMD_WHP_WB: begin
          whp_q    <= sat20(f_r);
          wprior_q <= wlp2_q;
        end
        CMD_CLP_WB: clp_q <= sat20(26'(clp_q) + f_r);
        CMD_CHP_WB: begin
          chp_q    <= sat20(f_r);
          cprior_q <= clp_q;
        end
        CMD_CACC: begin
          crack_pos_q <= crack_pos_q + 9'd1;
          crack_rem_q <= crack_rem_q - 9'd1;
        end
        CMD_TACC: begin
          tick_pos_q <= tick_pos_q + 9'd1;
          tick_rem_q <= tick_rem_q - 9'd1;
        end
        default: ;
      endcase
    end
  end

  assign status_o.whir_act  = (env_q > ENV_WHIR_GATE);
  assign status_o.crack_act = (crack_rem_q != '0);
  assign status_o.tick_act  = (tick_rem_q != '0);
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign mixed_sample_o = mixed_q;

endmodule

`default_nettype wire

### design/drive_noise_synth_mixer_top.sv
// Top level of the drive noise synthesizer and mixer.
// Sequencing: after a tick item (op 0) is accepted, the gate step runs, then the motor whir,
//   the step crack and the index tick, each only while it sounds, and then the output step.
// Input: a tick item keeps the input closed until its result enters the output slot, which
//   waits while the slot is still full; its products all go through the single shared
//   36x26 multiplier used by every filter, noise and scale product. Op 1 and 2 leave it open.
// Reset: rst_ni clears all synth state, the config registers to defaults and the output slot.
`default_nettype none

module drive_noise_synth_mixer_top #(
  parameter int unsigned CrackLength = dnsm_pkg::CRACK_LENGTH,
  parameter int unsigned TickLength  = dnsm_pkg::TICK_LENGTH
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  // input item
  input  wire                in_valid_i,
  output logic               in_ready_o,
  input  wire  [1:0]         op_i,
  input  wire                motor_on_i,
  input  wire  signed [15:0] buzzer_sample_i,
  // result item
  output logic               out_valid_o,
  input  wire                out_ready_i,
  output logic signed [15:0] mixed_sample_o,
  // config writes
  input  wire                cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire  [2:0]         cfg_index_i,
  input  wire  [24:0]        cfg_data_i
);
  import dnsm_pkg::*;

  cmd_e       cmd;
  dp_status_t status;

  // Register writes are always accepted; drop writes to unused indexes.
  assign cfg_ready_o = 1'b1;

  // Sequencer: takes items only from its idle state, then steps the whir, crack and tick
  // in that order, skipping any that are silent, and holds the finished item until the
  // output slot is free.
  dnsm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .op_i       (op_i),
    .status_i   (status),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd)
  );

  // Datapath: holds the synth state, the decay ROMs, the shared multiplier, the
  // mix accumulator and the output register that parts the output side from the work.
  dnsm_datapath #(
    .CrackLength (CrackLength),
    .TickLength  (TickLength)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .motor_on_i      (motor_on_i),
    .buzzer_sample_i (buzzer_sample_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .mixed_sample_o  (mixed_sample_o),
    .status_o        (status)
  );

endmodule

`default_nettype wire

### design/dnsm_checker.sv
// Port-level checks of the drive noise synthesizer, bound to the top level.
`default_nettype none

module dnsm_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        in_valid_i,
  input wire        in_ready_o,
  input wire [1:0]  op_i,
  input wire        out_valid_o,
  input wire        out_ready_i,
  input wire [15:0] mixed_sample_o
);
  import dnsm_pkg::*;

  // A stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(mixed_sample_o))
    else $error("result dropped or changed while stalled");

  // Taking a tick item closes the input side.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && op_i == OP_TICK |=> !in_ready_o)
    else $error("input taken while a tick item is in work");

  // Motor and step items make no result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && op_i != OP_TICK && !out_valid_o |=> !out_valid_o)
    else $error("result appeared without a tick item");

  // A result never appears in the cycle right after a tick is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && op_i == OP_TICK && !out_valid_o |=> !out_valid_o)
    else $error("result came too early");

endmodule

bind drive_noise_synth_mixer_top dnsm_checker u_dnsm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .op_i           (op_i),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .mixed_sample_o (mixed_sample_o)
);

`default_nettype wire
